/* rtl/fcf_pkg.sv */
// Shared types and constants of the fully connected forward unit.
// Used by fcf_cell, fcf_mac and fully_connected_forward_unit; depends on nothing.
`default_nettype none

package fcf_pkg;

   localparam int IN_MAX_DEF  = 256;
   localparam int OUT_MAX_DEF = 64;

   localparam int CMD_W    = 2;
   localparam int IN_IDX_W = 8;
   localparam int OUT_IDX_W = 6;
   localparam int SAMPLE_W = 16;
   localparam int BIAS_W   = 32;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 40;
   localparam int RESULT_W = 32;
   localparam int IN_CNT_W  = 9;
   localparam int OUT_CNT_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_WRITE_WEIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_BIAS   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FEED         = 2'd2;

   localparam logic REG_INPUT_COUNT  = 1'b0;
   localparam logic REG_OUTPUT_COUNT = 1'b1;

   typedef struct packed {
      logic valid;
      logic first;
   } mac_ctl_type;

endpackage

`default_nettype wire

/* rtl/fcf_cell.sv */
// One accumulator cell of the ring: holds one output channel's 40-bit sum.
// Depends on fcf_pkg for the accumulator width.
`default_nettype none

module fcf_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift_en,
   input  wire logic [fcf_pkg::ACC_W-1:0]  acc_in,
   output logic      [fcf_pkg::ACC_W-1:0]  acc_out
);

   logic [fcf_pkg::ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (shift_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

`default_nettype wire

/* rtl/fcf_mac.sv */
// Shared multiply-accumulate unit: registered Q16.16 product, then 40-bit add
// onto the ring head or onto the bias. Depends on fcf_pkg.
`default_nettype none

module fcf_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fcf_pkg::mac_ctl_type                ctl_in,
   input  wire logic signed [fcf_pkg::SAMPLE_W-1:0] act,
   input  wire logic signed [fcf_pkg::SAMPLE_W-1:0] weight,
   input  wire logic signed [fcf_pkg::BIAS_W-1:0]   bias,
   input  wire logic signed [fcf_pkg::ACC_W-1:0]    head,
   output fcf_pkg::mac_ctl_type                     ctl_out,
   output logic signed [fcf_pkg::ACC_W-1:0]         sum
);

   fcf_pkg::mac_ctl_type                ctl_ff;
   logic signed [fcf_pkg::PROD_W-1:0]   prod_ff;
   logic signed [fcf_pkg::PROD_W-1:0]   prod_in;
   logic signed [fcf_pkg::BIAS_W-1:0]   bias_ff;
   logic signed [fcf_pkg::ACC_W-1:0]    base;

   // zero activation contributes nothing, whatever the weight entry holds
   assign prod_in = (act == '0) ? '0
                    : fcf_pkg::PROD_W'(act) * fcf_pkg::PROD_W'(weight);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      prod_ff <= prod_in;
      bias_ff <= bias;
   end

   assign base    = ctl_ff.first ? fcf_pkg::ACC_W'(bias_ff) : head;
   assign sum     = base + fcf_pkg::ACC_W'(prod_ff);
   assign ctl_out = ctl_ff;

endmodule

`default_nettype wire

/* rtl/fully_connected_forward_unit.sv */
// Fully connected layer forward unit: weight and bias stores, accumulator ring, control.
// Depends on fcf_pkg, fcf_cell and fcf_mac.
//
// A weight or bias write beat is taken while idle and busy stays low. A feed beat keeps busy
// high while the single multiply-accumulate unit visits every cell of the accumulator ring
// once, one weight read per cycle, and through pipeline fill and drain. The beat that
// completes a sample then emits output_count results (clamped to 1..OUT_MAX), one per cycle,
// each on the rsp_ ports for one cycle under rsp_strobe; the receiver cannot stall them.
`default_nettype none

module fully_connected_forward_unit #(
   parameter int IN_MAX  = fcf_pkg::IN_MAX_DEF,
   parameter int OUT_MAX = fcf_pkg::OUT_MAX_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic [fcf_pkg::CMD_W-1:0]                req_cmd,
   input  wire logic [fcf_pkg::IN_IDX_W-1:0]             req_in_index,
   input  wire logic [fcf_pkg::OUT_IDX_W-1:0]            req_out_index,
   input  wire logic signed [fcf_pkg::SAMPLE_W-1:0]      req_sample_value,
   input  wire logic signed [fcf_pkg::BIAS_W-1:0]        req_bias_value,
   output logic                                          rsp_strobe,
   output logic [fcf_pkg::OUT_IDX_W-1:0]                 rsp_result_index,
   output logic signed [fcf_pkg::RESULT_W-1:0]           rsp_result_value,
   output logic                                          rsp_result_last,
   input  wire logic                                     psel,
   input  wire logic                                     penable,
   input  wire logic                                     pwrite,
   input  wire logic [fcf_pkg::CSR_ADDR_W-1:0]           paddr,
   input  wire logic [fcf_pkg::CSR_DATA_W-1:0]           pwdata,
   output logic [fcf_pkg::CSR_DATA_W-1:0]                prdata,
   output logic                                          pready
);

   localparam int IW   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
   localparam int OW   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
   localparam int CNTW = $clog2(IN_MAX + 1);
   localparam int OCW  = $clog2(OUT_MAX + 1);
   localparam int WT_DEPTH   = 1 << (IW + OW);
   localparam int BIAS_DEPTH = 1 << OW;

   typedef enum logic [1:0] {S_IDLE, S_MAC, S_DRAIN, S_EMIT} state_type;

   state_type st_ff;

   logic [fcf_pkg::IN_CNT_W-1:0]  input_count_ff;
   logic [fcf_pkg::OUT_CNT_W-1:0] output_count_ff;
   logic [CNTW-1:0]               in_used;
   logic [OCW-1:0]                out_used;

   logic [CNTW-1:0]               act_cnt_ff;
   logic [IW-1:0]                 row_ff;
   logic                          first_ff;
   logic                          last_ff;
   logic signed [fcf_pkg::SAMPLE_W-1:0] x_ff;
   logic [OW-1:0]                 issue_k_ff;
   logic [OW-1:0]                 emit_k_ff;

   logic                          take;
   logic                          wt_wr;
   logic                          bias_wr;
   logic                          emit_last;

   logic signed [fcf_pkg::SAMPLE_W-1:0] weight_mem_ff [WT_DEPTH];
   logic signed [fcf_pkg::BIAS_W-1:0]   bias_mem_ff [BIAS_DEPTH];
   logic signed [fcf_pkg::SAMPLE_W-1:0] wt_rdata_ff;
   logic signed [fcf_pkg::BIAS_W-1:0]   bias_rdata_ff;

   fcf_pkg::mac_ctl_type          a_ctl_ff;
   fcf_pkg::mac_ctl_type          c_ctl;
   logic signed [fcf_pkg::ACC_W-1:0] mac_sum;
   logic [fcf_pkg::ACC_W-1:0]     acc_chain [OUT_MAX];
   logic [fcf_pkg::ACC_W-1:0]     tail_in;
   logic                          shift_en;
   logic signed [fcf_pkg::RESULT_W-1:0] sat_value;

   logic                          rsp_strobe_ff;
   logic [fcf_pkg::OUT_IDX_W-1:0] rsp_index_ff;
   logic signed [fcf_pkg::RESULT_W-1:0] rsp_value_ff;
   logic                          rsp_last_ff;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         input_count_ff  <= fcf_pkg::IN_CNT_W'(1);
         output_count_ff <= fcf_pkg::OUT_CNT_W'(1);
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            fcf_pkg::REG_INPUT_COUNT:  input_count_ff  <= pwdata[fcf_pkg::IN_CNT_W-1:0];
            fcf_pkg::REG_OUTPUT_COUNT: output_count_ff <= pwdata[fcf_pkg::OUT_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         fcf_pkg::REG_INPUT_COUNT:  prdata = fcf_pkg::CSR_DATA_W'(input_count_ff);
         fcf_pkg::REG_OUTPUT_COUNT: prdata = fcf_pkg::CSR_DATA_W'(output_count_ff);
         default:                   prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   always_comb begin
      if (input_count_ff == '0) begin
         in_used = CNTW'(1);
      end else if (32'(input_count_ff) > IN_MAX) begin
         in_used = CNTW'(IN_MAX);
      end else begin
         in_used = CNTW'(input_count_ff);
      end
      if (output_count_ff == '0) begin
         out_used = OCW'(1);
      end else if (32'(output_count_ff) > OUT_MAX) begin
         out_used = OCW'(OUT_MAX);
      end else begin
         out_used = OCW'(output_count_ff);
      end
   end

   assign busy    = (st_ff != S_IDLE);
   assign take    = start && !busy;
   assign wt_wr   = take && (req_cmd == fcf_pkg::CMD_WRITE_WEIGHT)
                    && (32'(req_in_index) < IN_MAX) && (32'(req_out_index) < OUT_MAX);
   assign bias_wr = take && (req_cmd == fcf_pkg::CMD_WRITE_BIAS)
                    && (32'(req_out_index) < OUT_MAX);

   // weight and bias stores
   always_ff @(posedge clock) begin
      if (wt_wr) begin
         weight_mem_ff[{IW'(req_in_index), OW'(req_out_index)}] <= req_sample_value;
      end
      if (bias_wr) begin
         bias_mem_ff[OW'(req_out_index)] <= req_bias_value;
      end
      wt_rdata_ff   <= weight_mem_ff[{row_ff, issue_k_ff}];
      bias_rdata_ff <= bias_mem_ff[issue_k_ff];
   end

   fcf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (a_ctl_ff),
      .act     (x_ff),
      .weight  (wt_rdata_ff),
      .bias    (bias_rdata_ff),
      .head    (acc_chain[0]),
      .ctl_out (c_ctl),
      .sum     (mac_sum)
   );

   // accumulator ring: head feeds the MAC, new sum enters at the tail
   assign shift_en = c_ctl.valid || (st_ff == S_EMIT);
   assign tail_in  = (st_ff == S_EMIT) ? acc_chain[0] : mac_sum;

   for (genvar i = 0; i < OUT_MAX; i++) begin : g_ring
      logic [fcf_pkg::ACC_W-1:0] cell_in;
      if (i == OUT_MAX - 1) begin : g_tail
         assign cell_in = tail_in;
      end else begin : g_mid
         assign cell_in = acc_chain[i+1];
      end
      fcf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .acc_in   (cell_in),
         .acc_out  (acc_chain[i])
      );
   end

   always_comb begin
      if ($signed(acc_chain[0]) > 40'sd2147483647) begin
         sat_value = 32'sh7FFFFFFF;
      end else if ($signed(acc_chain[0]) < -40'sd2147483648) begin
         sat_value = 32'sh80000000;
      end else begin
         sat_value = acc_chain[0][fcf_pkg::RESULT_W-1:0];
      end
   end

   assign emit_last = (OCW'(emit_k_ff) + OCW'(1)) == out_used;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         act_cnt_ff    <= '0;
         issue_k_ff    <= '0;
         emit_k_ff     <= '0;
         a_ctl_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         a_ctl_ff.valid <= 1'b0;
         a_ctl_ff.first <= first_ff;
         rsp_strobe_ff  <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (take && (req_cmd == fcf_pkg::CMD_FEED)) begin
                  x_ff       <= req_sample_value;
                  row_ff     <= IW'(act_cnt_ff);
                  first_ff   <= (act_cnt_ff == '0);
                  last_ff    <= (act_cnt_ff + CNTW'(1)) >= in_used;
                  act_cnt_ff <= ((act_cnt_ff + CNTW'(1)) >= in_used) ? '0
                                : act_cnt_ff + CNTW'(1);
                  issue_k_ff <= '0;
                  st_ff      <= S_MAC;
               end
            end
            S_MAC: begin
               a_ctl_ff.valid <= 1'b1;
               if (issue_k_ff == OW'(OUT_MAX - 1)) begin
                  st_ff <= S_DRAIN;
               end else begin
                  issue_k_ff <= issue_k_ff + OW'(1);
               end
            end
            S_DRAIN: begin
               if (!a_ctl_ff.valid && !c_ctl.valid) begin
                  emit_k_ff <= '0;
                  st_ff     <= last_ff ? S_EMIT : S_IDLE;
               end
            end
            S_EMIT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_index_ff  <= fcf_pkg::OUT_IDX_W'(emit_k_ff);
               rsp_value_ff  <= sat_value;
               rsp_last_ff   <= emit_last;
               emit_k_ff     <= emit_k_ff + OW'(1);
               if (emit_last) begin
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_last  = rsp_last_ff;

`ifndef SYNTHESIS
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(st_ff == S_EMIT))
      else $error("result beat without an emit cycle");

   a_feed_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (take && (req_cmd == fcf_pkg::CMD_FEED)) |=> busy)
      else $error("feed beat did not start work");

   a_ring_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE) |-> (!c_ctl.valid && !a_ctl_ff.valid))
      else $error("MAC pipeline active while idle");

   a_issue_from_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(st_ff == S_MAC) |-> (issue_k_ff == '0))
      else $error("ring sweep did not start at channel zero");
`endif

endmodule

`default_nettype wire
